[sv/wssc_pkg.sv]
// package with sizes, state type and control bundle for the window score subarray counter
`timescale 1ns / 1ps

package wssc_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_BITS   = 16;
    localparam int COUNT_BITS   = 48;
    localparam int THR_BITS     = 48;

    localparam int PTR_BITS  = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS  = VALUE_BITS + $clog2(WINDOW_DEPTH + 1);
    localparam int PROD_BITS = SUM_BITS + LEN_BITS;
    localparam int CMP_BITS  = (PROD_BITS > THR_BITS) ? PROD_BITS : THR_BITS;

    localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(WINDOW_DEPTH - 1);
    localparam logic [LEN_BITS-1:0]   LEN_FULL  = LEN_BITS'(WINDOW_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FORCE,
        ST_PUSH,
        ST_MUL,
        ST_CMP
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic evict;
        logic set_ovf;
        logic push;
        logic finish;
    } t_ctrl;

endpackage

[sv/window_score_subarray_counter.sv]
// a full window first evicts its oldest value and sets overflow, then the item is pushed
// and score checked, each score check being a multiply then compare; each high score
// evicts the oldest value and checks again; the result then waits for a free output
// a new item is taken only in idle, after the previous item's result is formed
// the multiplier and the window memory read port are shared by every eviction step
// reset: synchronous active low, clears window, count and flags, threshold returns to 1
`timescale 1ns / 1ps

module window_score_subarray_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wssc_pkg::THR_BITS-1:0]    i_cfg_data,
    // input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [wssc_pkg::VALUE_BITS-1:0]  i_value,
    input  logic                             i_last,
    // result item channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [47:0]                      o_running_count,
    output logic [wssc_pkg::LEN_BITS-1:0]    o_window_length,
    output logic                             o_overflow,
    output logic                             o_final_res
);
    import wssc_pkg::*;

    t_state r_state, n_state;
    t_ctrl  ctl;

    logic [THR_BITS-1:0]   r_thr;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_last;
    logic [PTR_BITS-1:0]   r_ptr, n_ptr;
    logic [LEN_BITS-1:0]   r_count, n_count;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_ovf;
    logic [PROD_BITS-1:0]  r_prod;
    logic [VALUE_BITS-1:0] r_rdata;
    logic [VALUE_BITS-1:0] mem [WINDOW_DEPTH];

    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic [LEN_BITS-1:0]   r_out_len;
    logic                  r_out_ovf;
    logic                  r_out_last;

    logic                  score_high;
    logic                  out_free;
    logic [LEN_BITS:0]     slot_sum;
    logic [PTR_BITS-1:0]   slot;
    logic [COUNT_BITS:0]   total_ext;
    logic [COUNT_BITS-1:0] total_sat;

    // score check against threshold, exact
    assign score_high = (r_count != '0) &&
                        (CMP_BITS'(r_prod) >= CMP_BITS'(r_thr));
    assign out_free   = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_count == LEN_FULL) ? ST_FORCE : ST_PUSH;
                end
            end
            ST_FORCE: n_state = ST_PUSH;
            ST_PUSH:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_CMP;
            ST_CMP: begin
                if (score_high) begin
                    n_state = ST_MUL;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        ctl = '0;
        case (r_state)
            ST_IDLE:  ctl.in_ready = 1'b1;
            ST_FORCE: begin
                ctl.evict   = 1'b1;
                ctl.set_ovf = 1'b1;
            end
            ST_PUSH:  ctl.push = 1'b1;
            ST_CMP: begin
                ctl.evict  = score_high;
                ctl.finish = !score_high && out_free;
            end
            default:  ctl = '0;
        endcase
    end

    // write slot behind the newest value, wrapping
    assign slot_sum = {1'b0, r_count} + (LEN_BITS + 1)'(r_ptr);
    assign slot = (slot_sum >= (LEN_BITS + 1)'(WINDOW_DEPTH))
                ? PTR_BITS'(slot_sum - (LEN_BITS + 1)'(WINDOW_DEPTH))
                : PTR_BITS'(slot_sum);

    // shared evict / push unit on pointer, length and sum
    always_comb begin
        n_ptr   = r_ptr;
        n_count = r_count;
        n_sum   = r_sum;
        if (ctl.evict) begin
            n_ptr   = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
            n_count = r_count - 1'b1;
            n_sum   = r_sum - SUM_BITS'(r_rdata);
        end else if (ctl.push) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + SUM_BITS'(r_value);
        end
    end

    // saturating running count
    assign total_ext = {1'b0, r_total} + (COUNT_BITS + 1)'(r_count);
    assign total_sat = total_ext[COUNT_BITS] ? COUNT_MAX : total_ext[COUNT_BITS-1:0];

    // window memory, read port follows the oldest pointer
    always_ff @(posedge i_clk) begin
        if (ctl.push) begin
            mem[slot] <= r_value;
        end
        r_rdata <= mem[r_ptr];
    end

    // sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (ctl.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (ctl.finish && r_last) begin
                r_ptr   <= '0;
                r_count <= '0;
                r_sum   <= '0;
                r_total <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_ptr   <= n_ptr;
                r_count <= n_count;
                r_sum   <= n_sum;
                if (ctl.finish) begin
                    r_total <= total_sat;
                end
            end
        end
    end

    // item capture and product register
    always_ff @(posedge i_clk) begin
        if (ctl.in_ready && i_in_valid) begin
            r_value <= i_value;
            r_last  <= i_last;
        end
        r_prod <= PROD_BITS'(r_sum) * PROD_BITS'(r_count);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_out_count <= total_sat;
            r_out_len   <= r_count;
            r_out_ovf   <= r_ovf;
            r_out_last  <= r_last;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = ctl.in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_running_count = 48'(r_out_count);
    assign o_window_length = r_out_len;
    assign o_overflow      = r_out_ovf;
    assign o_final_res     = r_out_last;

`ifndef SYNTHESIS
    // window never holds more than the store depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_FULL)
        else $error("window length beyond store depth");

    // an empty window carries no sum
    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_sum == '0)
        else $error("empty window with nonzero sum");

    // a finished last item leaves a cleared sequence
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.finish && r_last |=> r_count == '0 && r_total == '0 && !r_ovf)
        else $error("sequence state not cleared after last item");

    // a result is only formed when the result register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.finish |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before taken");
`endif

endmodule
